@@ src/gmc_pkg.sv @@
// Shared types, constants and a helper function for the gate motor controller.
package gmc_pkg;

  localparam int TIMER_BITS = 14;
  localparam int CMP_W = (TIMER_BITS + 1 > 15) ? TIMER_BITS + 1 : 15;

  typedef logic [TIMER_BITS-1:0] tick_t;
  typedef logic [CMP_W-1:0] cmp_t;

  localparam cmp_t TMAX = cmp_t'({TIMER_BITS{1'b1}});

  localparam logic [13:0] RUN_LIMIT_RST = 14'd12000;
  localparam logic [9:0] SEP_TICKS_RST = 10'd300;
  localparam logic [7:0] LAMP_TICKS_RST = 8'd10;

  localparam logic [1:0] REG_RUN_LIMIT = 2'd0;
  localparam logic [1:0] REG_SEP_TICKS = 2'd1;
  localparam logic [1:0] REG_LAMP_TICKS = 2'd2;

  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_BOTH = 2'd1;
  localparam logic [1:0] FAULT_TIMEOUT = 2'd2;

  localparam logic [2:0] CODE_START = 3'd0;
  localparam logic [2:0] CODE_CLOSED = 3'd1;
  localparam logic [2:0] CODE_OPEN = 3'd2;
  localparam logic [2:0] CODE_CLOSING = 3'd3;
  localparam logic [2:0] CODE_OPENING = 3'd4;
  localparam logic [2:0] CODE_ERROR = 3'd5;

  typedef enum logic [5:0] {
    MODE_START   = 6'b000001,
    MODE_CLOSED  = 6'b000010,
    MODE_OPEN    = 6'b000100,
    MODE_CLOSING = 6'b001000,
    MODE_OPENING = 6'b010000,
    MODE_ERROR   = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [13:0] run_time_limit;
    logic [9:0]  separation_ticks;
    logic [7:0]  lamp_test_ticks;
  } cfg_t;

  typedef struct packed {
    logic limit_closed;
    logic limit_open;
    logic push_cmd;
  } tick_in_t;

  typedef struct packed {
    logic       motor_open;
    logic       motor_close;
    logic       lamp_opening;
    logic       lamp_closing;
    logic       lamp_error;
    logic [1:0] fault_code;
    logic [2:0] mode_now;
  } result_t;

  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] c;
    case (m)
      MODE_CLOSED:  c = CODE_CLOSED;
      MODE_OPEN:    c = CODE_OPEN;
      MODE_CLOSING: c = CODE_CLOSING;
      MODE_OPENING: c = CODE_OPENING;
      MODE_ERROR:   c = CODE_ERROR;
      default:      c = CODE_START;
    endcase
    return c;
  endfunction

endpackage

@@ src/gate_motor_controller.sv @@
// Top level of the gate motor controller: input stage, core, result stage and registers.
// A tick word's result is registered when the input stage advances. Throughput: one
// word per cycle unless out_ready stalls; the input stage and the result register form
// a two-deep pipeline whose only loop is the mode and counter update in the core.
// Reset (synchronous, rst_n low): start mode, no fault, counter and separation cleared,
// both channels empty, configuration registers back to 12000, 300 and 10 ticks.
module gate_motor_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_limit_closed,
  input  logic        in_limit_open,
  input  logic        in_push_cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_motor_open,
  output logic        out_motor_close,
  output logic        out_lamp_opening,
  output logic        out_lamp_closing,
  output logic        out_lamp_error,
  output logic [1:0]  out_fault_code,
  output logic [2:0]  out_mode_now,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  gmc_pkg::cfg_t     cfg;
  gmc_pkg::tick_in_t s1_data_r;
  logic              s1_valid_r;
  logic              s1_adv;
  gmc_pkg::result_t  res;
  gmc_pkg::result_t  res_r;
  logic              out_valid_r;

  assign s1_adv = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  gmc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  gmc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (s1_adv),
    .tick_in (s1_data_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r.limit_closed <= in_limit_closed;
      s1_data_r.limit_open <= in_limit_open;
      s1_data_r.push_cmd <= in_push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_motor_open = res_r.motor_open;
  assign out_motor_close = res_r.motor_close;
  assign out_lamp_opening = res_r.lamp_opening;
  assign out_lamp_closing = res_r.lamp_closing;
  assign out_lamp_error = res_r.lamp_error;
  assign out_fault_code = res_r.fault_code;
  assign out_mode_now = res_r.mode_now;

endmodule

@@ src/gmc_cfg.sv @@
// Configuration register file behind the APB-style port.
module gmc_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [3:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output gmc_pkg::cfg_t     cfg
);

  gmc_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx = cfg_paddr[3:2];
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.run_time_limit <= gmc_pkg::RUN_LIMIT_RST;
      cfg_r.separation_ticks <= gmc_pkg::SEP_TICKS_RST;
      cfg_r.lamp_test_ticks <= gmc_pkg::LAMP_TICKS_RST;
    end else if (wr_en) begin
      case (reg_idx)
        gmc_pkg::REG_RUN_LIMIT: cfg_r.run_time_limit <= cfg_pwdata[13:0];
        gmc_pkg::REG_SEP_TICKS: cfg_r.separation_ticks <= cfg_pwdata[9:0];
        gmc_pkg::REG_LAMP_TICKS: cfg_r.lamp_test_ticks <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      gmc_pkg::REG_RUN_LIMIT: cfg_prdata = {18'd0, cfg_r.run_time_limit};
      gmc_pkg::REG_SEP_TICKS: cfg_prdata = {22'd0, cfg_r.separation_ticks};
      gmc_pkg::REG_LAMP_TICKS: cfg_prdata = {24'd0, cfg_r.lamp_test_ticks};
      default: cfg_prdata = 32'd0;
    endcase
  end

endmodule

@@ src/gmc_core.sv @@
// Mode state, tick counter and result logic for one tick word.
module gmc_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  gmc_pkg::tick_in_t  tick_in,
  input  gmc_pkg::cfg_t      cfg,
  output gmc_pkg::result_t   res
);

  gmc_pkg::mode_t mode_r, mode_nxt;
  gmc_pkg::mode_t origin_r, origin_nxt;
  logic [1:0]     fault_r, fault_nxt;
  gmc_pkg::tick_t tick_r, tick_nxt;
  logic           sep_r, sep_nxt;

  gmc_pkg::cmp_t  cnt_next;
  gmc_pkg::cmp_t  sep_lim;
  gmc_pkg::cmp_t  run_lim;
  gmc_pkg::cmp_t  lamp_lim;
  logic           far_sw;
  gmc_pkg::mode_t done_mode;
  logic           lamp_test;
  logic           sep_on;

  assign cnt_next = gmc_pkg::cmp_t'(tick_r) + gmc_pkg::cmp_t'(1);
  assign sep_lim = gmc_pkg::cmp_t'(cfg.separation_ticks);
  assign run_lim = gmc_pkg::cmp_t'(cfg.run_time_limit);
  assign lamp_lim = gmc_pkg::cmp_t'(cfg.lamp_test_ticks);
  assign sep_on = (cfg.separation_ticks != 10'd0);
  assign far_sw = (mode_r == gmc_pkg::MODE_CLOSING) ? tick_in.limit_closed
                                                    : tick_in.limit_open;
  assign done_mode = (mode_r == gmc_pkg::MODE_CLOSING) ? gmc_pkg::MODE_CLOSED
                                                       : gmc_pkg::MODE_OPEN;

  always_comb begin
    mode_nxt = mode_r;
    origin_nxt = origin_r;
    fault_nxt = fault_r;
    tick_nxt = tick_r;
    sep_nxt = sep_r;
    lamp_test = 1'b0;
    case (mode_r)
      gmc_pkg::MODE_CLOSED: begin
        if (tick_in.push_cmd) begin
          mode_nxt = gmc_pkg::MODE_OPENING;
          tick_nxt = '0;
          sep_nxt = sep_on;
        end
      end
      gmc_pkg::MODE_OPEN: begin
        if (tick_in.push_cmd) begin
          mode_nxt = gmc_pkg::MODE_CLOSING;
          tick_nxt = '0;
          sep_nxt = sep_on;
        end
      end
      gmc_pkg::MODE_CLOSING, gmc_pkg::MODE_OPENING: begin
        if (sep_r) begin
          if (cnt_next >= sep_lim || cnt_next > gmc_pkg::TMAX) begin
            sep_nxt = 1'b0;
            tick_nxt = '0;
          end else begin
            tick_nxt = cnt_next[gmc_pkg::TIMER_BITS-1:0];
          end
        end else if (far_sw) begin
          mode_nxt = done_mode;
          tick_nxt = '0;
        end else if (cnt_next > run_lim || cnt_next > gmc_pkg::TMAX) begin
          mode_nxt = gmc_pkg::MODE_ERROR;
          fault_nxt = gmc_pkg::FAULT_TIMEOUT;
          origin_nxt = mode_r;
          tick_nxt = '0;
          sep_nxt = 1'b0;
        end else begin
          tick_nxt = cnt_next[gmc_pkg::TIMER_BITS-1:0];
        end
      end
      gmc_pkg::MODE_ERROR: begin
        if (tick_in.push_cmd) begin
          fault_nxt = gmc_pkg::FAULT_NONE;
          tick_nxt = '0;
          if (origin_r == gmc_pkg::MODE_CLOSING || origin_r == gmc_pkg::MODE_OPENING) begin
            mode_nxt = origin_r;
            sep_nxt = sep_on;
          end else begin
            mode_nxt = gmc_pkg::MODE_START;
            sep_nxt = 1'b0;
          end
        end
      end
      default: begin
        mode_nxt = gmc_pkg::MODE_START;
        if (gmc_pkg::cmp_t'(tick_r) < lamp_lim) begin
          tick_nxt = cnt_next[gmc_pkg::TIMER_BITS-1:0];
          lamp_test = 1'b1;
        end else if (tick_in.limit_closed && !tick_in.limit_open) begin
          mode_nxt = gmc_pkg::MODE_CLOSED;
          tick_nxt = '0;
        end else if (tick_in.limit_closed && tick_in.limit_open) begin
          mode_nxt = gmc_pkg::MODE_ERROR;
          fault_nxt = gmc_pkg::FAULT_BOTH;
          origin_nxt = gmc_pkg::MODE_START;
          tick_nxt = '0;
          sep_nxt = 1'b0;
        end else begin
          mode_nxt = gmc_pkg::MODE_CLOSING;
          tick_nxt = '0;
          sep_nxt = sep_on;
        end
      end
    endcase
  end

  always_comb begin
    res.motor_open = (mode_nxt == gmc_pkg::MODE_OPENING) && !lamp_test;
    res.motor_close = (mode_nxt == gmc_pkg::MODE_CLOSING) && !lamp_test;
    res.lamp_opening = lamp_test || (mode_nxt == gmc_pkg::MODE_OPENING);
    res.lamp_closing = lamp_test || (mode_nxt == gmc_pkg::MODE_CLOSING);
    res.lamp_error = lamp_test || (mode_nxt == gmc_pkg::MODE_ERROR);
    res.fault_code = fault_nxt;
    res.mode_now = gmc_pkg::mode_code(mode_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= gmc_pkg::MODE_START;
      origin_r <= gmc_pkg::MODE_START;
      fault_r <= gmc_pkg::FAULT_NONE;
      tick_r <= '0;
      sep_r <= 1'b0;
    end else if (adv) begin
      mode_r <= mode_nxt;
      origin_r <= origin_nxt;
      fault_r <= fault_nxt;
      tick_r <= tick_nxt;
      sep_r <= sep_nxt;
    end
  end

  a_fault_iff_error: assert property (@(posedge clk) disable iff (!rst_n)
    (fault_r != gmc_pkg::FAULT_NONE) == (mode_r == gmc_pkg::MODE_ERROR))
    else $error("Fault code and error mode disagree.");

  a_sep_only_moving: assert property (@(posedge clk) disable iff (!rst_n)
    sep_r |-> (mode_r == gmc_pkg::MODE_CLOSING || mode_r == gmc_pkg::MODE_OPENING))
    else $error("Separation flag set outside a moving mode.");

  a_one_motor: assert property (@(posedge clk) disable iff (!rst_n)
    !(res.motor_open && res.motor_close))
    else $error("Both motor drives requested.");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(adv) && $past(rst_n) |-> $stable(mode_r) && $stable(tick_r))
    else $error("Mode state changed without a tick word.");

endmodule
